FILE: src/mtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg: shared types and codes for the move-to-front list unit
// Command and result structs, operation and status codes, controller strobes.
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
        logic [3:0]         position;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] found_position;
        logic [4:0] entry_count;
    } t_result;

    // controller to datapath strobes
    typedef struct packed {
        logic load;
        logic cmp;
        logic upd;
    } t_ctrl;

endpackage

FILE: src/move_to_front_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_list_unit: move-to-front self-organising list
// A transaction is taken when start is high and busy is low. Each one passes
// through a compare cycle in which every list cell checks the value, and
// an update cycle in which the cells shift. busy is high only in the compare
// cycle, so a new transaction can be taken during the update of the last one.
// The result is registered on o_result, with o_done high for exactly one cycle
// in the cycle after the update; there is no back-pressure, the receiver must take it then.
// ----------------------------------------------------------------------------
module move_to_front_list_unit #(
    parameter int DEPTH = mtf_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mtf_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output mtf_pkg::t_result o_result
);
    import mtf_pkg::*;

    t_ctrl w_ctrl;

    mtf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctrl  (w_ctrl)
    );

    mtf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_cmd    (i_cmd),
        .o_result (o_result)
    );

    // an accepted transaction always enters the compare cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted without entering compare");

    // compare lasts exactly one cycle
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // every compare is followed by the update and then the result strobe
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> ##2 o_done)
        else $error("result strobe missing after compare");

    // a failed operation never reports a position
    a_fail_nopos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> (o_result.found_position == 5'd0))
        else $error("position reported on failed transaction");

endmodule

FILE: src/mtf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_ctrl: sequencer for the move-to-front list unit
// Steps each transaction through a compare cycle and an update cycle.
// ----------------------------------------------------------------------------
module mtf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_done,
    output mtf_pkg::t_ctrl o_ctrl
);
    import mtf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   w_accept;

    assign o_busy   = (r_state == S_CMP);
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                // next transaction may enter while this one writes back
                n_state = w_accept ? S_CMP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_UPD);
        end
    end

    assign o_done      = r_done;
    assign o_ctrl.load = w_accept;
    assign o_ctrl.cmp  = (r_state == S_CMP);
    assign o_ctrl.upd  = (r_state == S_UPD);

endmodule

FILE: src/mtf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_datapath: list cells, match logic and result register
// Per-cell compare against the command value, then a per-cell shift update.
// ----------------------------------------------------------------------------
module mtf_datapath #(
    parameter int DEPTH = mtf_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtf_pkg::t_ctrl   i_ctrl,
    input  mtf_pkg::t_cmd    i_cmd,
    output mtf_pkg::t_result o_result
);
    import mtf_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    t_cmd          r_cmd;
    logic [31:0]   r_entry [DEPTH];
    logic [31:0]   n_entry [DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_hit;
    logic [IW-1:0] r_idx;
    logic          n_hit;
    logic [IW-1:0] n_idx;
    t_result       r_result;
    t_result       n_result;
    logic [DEPTH-1:0] w_match;

    // entries are distinct, so at most one cell matches
    always_comb begin
        n_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_match[i] = (r_entry[i] == r_cmd.value) && (32'(i) < 32'(r_count));
            if (w_match[i]) n_idx = n_idx | IW'(i);
        end
        n_hit = |w_match;
    end

    always_comb begin
        n_entry  = r_entry;
        n_count  = r_count;
        n_result.status         = ST_MISS;
        n_result.found_position = '0;
        unique case (r_cmd.mode)
            MODE_INSERT: begin
                if (r_hit) begin
                    n_result.status = ST_DUP;
                end else if (32'(r_count) >= 32'(DEPTH)) begin
                    n_result.status = ST_FULL;
                end else begin
                    n_entry[0] = r_cmd.value;
                    for (int i = 1; i < DEPTH; i++) begin
                        n_entry[i] = r_entry[i-1];
                    end
                    n_count = CW'(r_count + 1'b1);
                    n_result.status = ST_OK;
                end
            end
            MODE_DELETE: begin
                if (32'(r_cmd.position) < 32'(r_count)) begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (32'(i) >= 32'(r_cmd.position)) n_entry[i] = r_entry[i+1];
                    end
                    n_count = CW'(r_count - 1'b1);
                    n_result.status = ST_OK;
                end
            end
            MODE_SEARCH: begin
                if (r_hit) begin
                    n_entry[0] = r_cmd.value;
                    for (int i = 1; i < DEPTH; i++) begin
                        if (32'(i) <= 32'(r_idx)) n_entry[i] = r_entry[i-1];
                    end
                    n_result.found_position = 5'(32'(r_idx) + 32'd1);
                    n_result.status = ST_OK;
                end
            end
            default: begin
            end
        endcase
        n_result.entry_count = 5'(32'(n_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.upd) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) r_cmd <= i_cmd;
        if (i_ctrl.cmp) begin
            r_hit <= n_hit;
            r_idx <= n_idx;
        end
        if (i_ctrl.upd) begin
            r_result <= n_result;
            for (int i = 0; i < DEPTH; i++) begin
                r_entry[i] <= n_entry[i];
            end
        end
    end

    assign o_result = r_result;

endmodule

FILE: test/move_to_front_list_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_list_unit_test: self-checking bench for the move-to-front list
// A clocked driver issues insert, delete, search and unused-mode transactions
// from a queue that the stimulus block fills. A shadow copy of the list predicts
// each result. A clocked monitor compares every strobed result, field by field,
// against the oldest prediction. The sender idles at three different rates.
// ----------------------------------------------------------------------------
module move_to_front_list_unit_test;

    import mtf_pkg::*;

    localparam int          DEPTH          = DEPTH_DEF;
    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 7;
    localparam int          STALL_LIMIT    = 2000;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          MAX_REPORTS    = 10;
    localparam int          POOL_SIZE      = 24;
    localparam logic [1:0]  MODE_UNUSED    = 2'd3;

    // mix of operations for one stretch of random stimulus
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_LOOKUP
    } t_mix;

    typedef struct {
        t_cmd        cmd;
        int unsigned idle_pct;
    } t_pending;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    t_pending    pending_cmds[$];
    t_result     expected_results[$];

    // shadow copy of the list
    logic [31:0] list_vals[DEPTH];
    int          list_len = 0;

    logic [31:0] value_pool[POOL_SIZE];
    int          fail_count   = 0;
    int          stall_cycles = 0;

    move_to_front_list_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    function automatic int find_entry(input logic [31:0] v);
        for (int i = 0; i < list_len; i++) begin
            if (list_vals[i] == v) begin
                return i;
            end
        end
        return -1;
    endfunction

    // applies one transaction to the shadow list and returns its result
    function automatic t_result apply_list_op(input t_cmd cmd);
        t_result res;
        int      hit;
        res                = '0;
        res.status         = ST_MISS;
        res.found_position = '0;
        case (cmd.mode)
            MODE_INSERT: begin
                hit = find_entry(cmd.value);
                if (hit >= 0) begin
                    res.status = ST_DUP;
                end else if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > 0; i--) begin
                        list_vals[i] = list_vals[i - 1];
                    end
                    list_vals[0] = cmd.value;
                    list_len++;
                    res.status = ST_OK;
                end
            end
            MODE_DELETE: begin
                if (int'(cmd.position) < list_len) begin
                    for (int i = cmd.position; i + 1 < list_len; i++) begin
                        list_vals[i] = list_vals[i + 1];
                    end
                    list_len--;
                    res.status = ST_OK;
                end
            end
            MODE_SEARCH: begin
                hit = find_entry(cmd.value);
                if (hit >= 0) begin
                    res.found_position = 5'(hit + 1);
                    for (int i = hit; i > 0; i--) begin
                        list_vals[i] = list_vals[i - 1];
                    end
                    list_vals[0] = cmd.value;
                    res.status = ST_OK;
                end
            end
            default: begin
            end
        endcase
        res.entry_count = 5'(list_len);
        return res;
    endfunction

    function automatic t_cmd make_cmd(input logic [1:0] mode, input logic [31:0] v,
                                      input logic [3:0] pos);
        t_cmd c;
        c.mode     = mode;
        c.value    = v;
        c.position = pos;
        return c;
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned slot;
        slot = $urandom_range(0, POOL_SIZE - 1);
        // let the pool drift so that fresh values keep turning up
        if ($urandom_range(0, 99) < 5) begin
            value_pool[slot] = $urandom;
        end
        if ($urandom_range(0, 99) < 75) begin
            return value_pool[slot];
        end
        return $urandom;
    endfunction

    function automatic t_cmd make_random_cmd(input t_mix mix);
        int unsigned r;
        int unsigned ins_lim;
        int unsigned del_lim;
        int unsigned srch_lim;
        logic [1:0]  mode;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:   begin ins_lim = 65; del_lim = 75; srch_lim = 97; end
            MIX_DRAIN:  begin ins_lim = 20; del_lim = 75; srch_lim = 97; end
            default:    begin ins_lim = 30; del_lim = 45; srch_lim = 97; end
        endcase
        if (r < ins_lim) begin
            mode = MODE_INSERT;
        end else if (r < del_lim) begin
            mode = MODE_DELETE;
        end else if (r < srch_lim) begin
            mode = MODE_SEARCH;
        end else begin
            mode = MODE_UNUSED;
        end
        return make_cmd(mode, pick_value(), 4'($urandom_range(0, 15)));
    endfunction

    task automatic queue_cmd(input t_cmd cmd, input int unsigned idle_pct);
        t_pending p;
        p.cmd      = cmd;
        p.idle_pct = idle_pct;
        pending_cmds.push_back(p);
    endtask

    task automatic queue_random(input int n, input int unsigned idle_pct);
        t_mix mix;
        mix = MIX_FILL;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                mix = t_mix'($urandom_range(0, 2));
            end
            queue_cmd(make_random_cmd(mix), idle_pct);
        end
    endtask

    // driver: issues the front transaction, holds it while the unit is busy
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy) begin
                // hold the pending transaction
            end else begin
                if (start) begin
                    expected_results.push_back(apply_list_op(pending_cmds[0].cmd));
                    void'(pending_cmds.pop_front());
                end
                if (pending_cmds.size() > 0 &&
                    $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
                    start <= 1'b1;
                    i_cmd <= pending_cmds[0].cmd;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed result must match the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result: status %0d found %0d count %0d",
                             o_result.status, o_result.found_position,
                             o_result.entry_count);
                end
            end else begin
                exp_res = expected_results.pop_front();
                if (o_result.status !== exp_res.status ||
                    o_result.found_position !== exp_res.found_position ||
                    o_result.entry_count !== exp_res.entry_count) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: status %0d/%0d found %0d/%0d count %0d/%0d (exp/act)",
                                 exp_res.status, o_result.status,
                                 exp_res.found_position, o_result.found_position,
                                 exp_res.entry_count, o_result.entry_count);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction or result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom;
        end

        // directed: empty list, unused mode, extremes, duplicates, edge positions
        queue_cmd(make_cmd(MODE_DELETE, 32'h0, 4'd0), 33);
        queue_cmd(make_cmd(MODE_SEARCH, 32'h0, 4'd0), 33);
        queue_cmd(make_cmd(MODE_UNUSED, 32'h1234_5678, 4'd0), 33);
        queue_cmd(make_cmd(MODE_INSERT, 32'h8000_0000, 4'd0), 33);
        queue_cmd(make_cmd(MODE_INSERT, 32'h7fff_ffff, 4'd15), 33);
        queue_cmd(make_cmd(MODE_INSERT, 32'h0000_0000, 4'd0), 33);
        queue_cmd(make_cmd(MODE_INSERT, 32'hffff_ffff, 4'd0), 33);
        queue_cmd(make_cmd(MODE_INSERT, 32'h7fff_ffff, 4'd0), 33);
        queue_cmd(make_cmd(MODE_SEARCH, 32'h8000_0000, 4'd0), 33);
        queue_cmd(make_cmd(MODE_SEARCH, 32'h8000_0000, 4'd0), 33);
        queue_cmd(make_cmd(MODE_SEARCH, 32'h5555_aaaa, 4'd0), 33);
        queue_cmd(make_cmd(MODE_DELETE, 32'h0, 4'd15), 33);
        queue_cmd(make_cmd(MODE_DELETE, 32'h0, 4'd4), 33);
        queue_cmd(make_cmd(MODE_DELETE, 32'h0, 4'd0), 33);
        queue_cmd(make_cmd(MODE_DELETE, 32'hffff_ffff, 4'd2), 33);
        queue_cmd(make_cmd(MODE_UNUSED, 32'hffff_ffff, 4'd15), 33);

        queue_random(240, 33);
        queue_random(230, 62);
        queue_random(230, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
